// ===== rtl/core/msgpack_scalar_encoder_defines.svh =====
// Assertion helpers used by the encoder queue module.
`ifndef MSGPACK_SCALAR_ENCODER_DEFINES_SVH
`define MSGPACK_SCALAR_ENCODER_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define MSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

   // Action codes carried on the request tuser.
   typedef enum logic [2:0] {
      ACT_NIL      = 3'd0,
      ACT_BOOL     = 3'd1,
      ACT_UNSIGNED = 3'd2,
      ACT_SIGNED   = 3'd3,
      ACT_FLOAT32  = 3'd4,
      ACT_FLOAT64  = 3'd5
   } action_type;

   // Standard MessagePack tag bytes.
   localparam logic [7:0] TAG_NIL     = 8'hC0;
   localparam logic [7:0] TAG_FALSE   = 8'hC2;
   localparam logic [7:0] TAG_TRUE    = 8'hC3;
   localparam logic [7:0] TAG_FLOAT32 = 8'hCA;
   localparam logic [7:0] TAG_FLOAT64 = 8'hCB;
   localparam logic [7:0] TAG_UINT8   = 8'hCC;
   localparam logic [7:0] TAG_UINT16  = 8'hCD;
   localparam logic [7:0] TAG_UINT32  = 8'hCE;
   localparam logic [7:0] TAG_UINT64  = 8'hCF;
   localparam logic [7:0] TAG_INT8    = 8'hD0;
   localparam logic [7:0] TAG_INT16   = 8'hD1;
   localparam logic [7:0] TAG_INT32   = 8'hD2;
   localparam logic [7:0] TAG_INT64   = 8'hD3;

   // Longest encoding is a tag plus eight payload bytes.
   localparam int MAX_BYTES = 9;
   localparam int COUNT_W   = 4;

   // One classified item, as passed from the front end to the serializer.
   typedef struct packed {
      logic        has_tag;
      logic [7:0]  tag;
      logic [3:0]  nbytes;   // payload bytes: 0, 1, 2, 4 or 8
      logic [63:0] payload;
   } enc_entry_type;

endpackage

// ===== rtl/core/msgpack_scalar_encoder.sv =====
// MessagePack scalar encoder. Each request word carries one typed scalar (the action code
// in tuser, the payload in tdata) and produces its MessagePack encoding as a run of
// response words, one byte each, tag byte first and payload big-endian, with tlast on
// the final byte. Nil and booleans give one byte, integers take the narrowest form
// (fixint, then 1, 2, 4 or 8 payload bytes after a tag), floats give a tag plus 4 or 8
// bytes. Requests with the unused action codes 6 and 7 are accepted and dropped with no
// output. The front end classifies a request in the cycle it is accepted and writes it
// into a small queue; the serializer drains the queue one byte per cycle, while the
// receiver keeps tready high, through a registered output. Throughput is set by that
// byte port: an item gives one word per byte, from 1 to 9, and consecutive items follow
// with no gap, so a new request is taken every cycle as long as the queue has room.
module msgpack_scalar_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   input  logic [7:0]  req_tuser,   // [2:0] action, [7:3] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] byte_out
   output logic        rsp_tlast
);
   import msc_pkg::*;

   logic          push_valid;
   logic          push_ready;
   enc_entry_type push_entry;
   logic          pop_valid;
   logic          pop;
   enc_entry_type pop_entry;

   // Front end: classify and pick the encoding form.
   msc_classify u_classify (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser[2:0]),
      .value      (req_tdata),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Queue between classification and byte emission.
   msc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Back end: emit the tag and payload bytes one word at a time.
   msc_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .entry_pop   (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== rtl/core/msc_classify.sv =====
module msc_classify (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            action,
   input  logic [63:0]           value,
   input  logic                  push_ready,
   output logic                  push_valid,
   output msc_pkg::enc_entry_type push_entry
);
   import msc_pkg::*;

   logic known;
   logic u_fix, u_8, u_16, u_32;
   logic s_fix, s_8, s_16, s_32;

   // Range checks by looking at the upper bits only.
   assign u_fix = ~|value[63:7];
   assign u_8   = ~|value[63:8];
   assign u_16  = ~|value[63:16];
   assign u_32  = ~|value[63:32];

   assign s_fix = (~|value[63:7]) | (&value[63:5]);
   assign s_8   = &value[63:7];
   assign s_16  = (~|value[63:15]) | (&value[63:15]);
   assign s_32  = (~|value[63:31]) | (&value[63:31]);

   always_comb begin
      known              = 1'b1;
      push_entry.has_tag = 1'b1;
      push_entry.tag     = TAG_NIL;
      push_entry.nbytes  = 4'd0;
      push_entry.payload = value;
      case (action_type'(action))
         ACT_NIL: begin
            push_entry.tag = TAG_NIL;
         end
         ACT_BOOL: begin
            push_entry.tag = value[0] ? TAG_TRUE : TAG_FALSE;
         end
         ACT_UNSIGNED: begin
            if (u_fix) begin
               push_entry.has_tag = 1'b0;
               push_entry.nbytes  = 4'd1;
            end else if (u_8) begin
               push_entry.tag    = TAG_UINT8;
               push_entry.nbytes = 4'd1;
            end else if (u_16) begin
               push_entry.tag    = TAG_UINT16;
               push_entry.nbytes = 4'd2;
            end else if (u_32) begin
               push_entry.tag    = TAG_UINT32;
               push_entry.nbytes = 4'd4;
            end else begin
               push_entry.tag    = TAG_UINT64;
               push_entry.nbytes = 4'd8;
            end
         end
         ACT_SIGNED: begin
            if (s_fix) begin
               push_entry.has_tag = 1'b0;
               push_entry.nbytes  = 4'd1;
            end else if (s_8) begin
               push_entry.tag    = TAG_INT8;
               push_entry.nbytes = 4'd1;
            end else if (s_16) begin
               push_entry.tag    = TAG_INT16;
               push_entry.nbytes = 4'd2;
            end else if (s_32) begin
               push_entry.tag    = TAG_INT32;
               push_entry.nbytes = 4'd4;
            end else begin
               push_entry.tag    = TAG_INT64;
               push_entry.nbytes = 4'd8;
            end
         end
         ACT_FLOAT32: begin
            push_entry.tag     = TAG_FLOAT32;
            push_entry.nbytes  = 4'd4;
            push_entry.payload = {32'd0, value[31:0]};
         end
         ACT_FLOAT64: begin
            push_entry.tag    = TAG_FLOAT64;
            push_entry.nbytes = 4'd8;
         end
         default: begin
            // Unused codes are consumed and produce no bytes.
            known = 1'b0;
         end
      endcase
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid & push_ready & known;

endmodule

// ===== rtl/core/msc_queue.sv =====
`include "msgpack_scalar_encoder_defines.svh"

module msc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  msc_pkg::enc_entry_type push_entry,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   pop_valid,
   output msc_pkg::enc_entry_type pop_entry
);
   import msc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   enc_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MSC_ASSERT(a_no_overflow, push |-> count_ff != FULL_CNT, "push into full queue")
   `MSC_ASSERT(a_no_underflow, pop |-> count_ff != '0, "pop from empty queue")
   `MSC_ASSERT(a_ptrs_match_count, (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff), "pointers disagree with empty count")
   `MSC_ASSERT_ALWAYS(a_reset_empty, reset |=> (count_ff == '0), "queue not empty after reset")

endmodule

// ===== rtl/core/msc_serializer.sv =====
module msc_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   entry_valid,
   input  msc_pkg::enc_entry_type entry,
   output logic                   entry_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import msc_pkg::*;

   logic [71:0]        shift_ff, shift_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff, valid_in;
   logic [7:0]         data_ff, data_in;
   logic               last_ff, last_in;
   logic               advance;
   logic [63:0]        aligned;

   // Put the most significant payload byte at the top of the word.
   always_comb begin
      case (entry.nbytes)
         4'd1:    aligned = {entry.payload[7:0], 56'd0};
         4'd2:    aligned = {entry.payload[15:0], 48'd0};
         4'd4:    aligned = {entry.payload[31:0], 32'd0};
         default: aligned = entry.payload;
      endcase
   end

   assign advance   = (count_ff != '0) && (!valid_ff || rsp_tready);
   assign entry_pop = entry_valid &&
                      ((count_ff == '0) || (advance && count_ff == COUNT_W'(1)));

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = shift_ff[71:64];
         last_in  = (count_ff == COUNT_W'(1));
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (entry_pop) begin
         shift_in = entry.has_tag ? {entry.tag, aligned} : {aligned, 8'd0};
         count_in = COUNT_W'(entry.nbytes) + COUNT_W'(entry.has_tag);
      end else if (advance) begin
         shift_in = {shift_ff[63:0], 8'd0};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== verif/tb_msgpack_scalar_encoder.sv =====
`timescale 1ns / 100ps

module tb_msgpack_scalar_encoder;
   import msc_pkg::*;

   // The two action codes that the encoder accepts and then drops without output.
   localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

   // Range limits of the compact integer forms.
   localparam longint POS_FIX_LIMIT = 128;
   localparam longint NEG_FIX_LOW   = -32;
   localparam longint INT8_LOW      = -128;
   localparam longint INT16_LOW     = -64'sh8000;
   localparam longint INT16_HIGH    = 64'sh7FFF;
   localparam longint INT32_LOW     = -64'sh8000_0000;
   localparam longint INT32_HIGH    = 64'sh7FFF_FFFF;

   // Bit positions around which the encoded size changes. Random payloads are often
   // placed close to these so that every size boundary gets hit from both sides.
   localparam int SIZE_EDGES [9] = '{5, 6, 7, 8, 15, 16, 31, 32, 63};

   localparam int RANDOM_SCALARS = 234;
   localparam int HOLD_AFTER     = 60;      // accepted scalars before the long output stall
   localparam int HOLD_CYCLES    = 120;
   localparam int DRAIN_CYCLES   = 24;      // wait after the last expected byte, to catch stray output
   localparam int CYCLE_LIMIT    = 200000;

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] value;
   } scalar_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } enc_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [7:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   scalar_type   scalars_to_send[$];
   enc_byte_type encoded_bytes_due[$];

   int scalars_accepted = 0;
   int scalars_queued   = 0;
   int bytes_checked    = 0;
   int mismatches       = 0;
   int cycle_count      = 0;
   int action_hits [8]  = '{default: 0};

   int req_gap    = 0;
   int rsp_stall  = 0;
   bit hold_begun = 1'b0;

   msgpack_scalar_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Appends one encoding to the expected byte stream: an optional tag byte, then the
   // low nbytes of the payload, most significant first. The final byte carries last.
   function automatic void push_encoding(input bit has_tag, input logic [7:0] tag,
                                         input logic [63:0] payload, input int nbytes);
      enc_byte_type due_byte;
      int           i;
      if (has_tag) begin
         due_byte.data = tag;
         due_byte.last = 1'(nbytes == 0);
         encoded_bytes_due.insert(encoded_bytes_due.size(), due_byte);
      end
      for (i = nbytes - 1; i >= 0; i--) begin
         due_byte.data = payload[8*i +: 8];
         due_byte.last = 1'(i == 0);
         encoded_bytes_due.insert(encoded_bytes_due.size(), due_byte);
      end
   endfunction

   // Works out the byte sequence that one accepted scalar must produce.
   function automatic void encode_scalar(input logic [2:0] action, input logic [63:0] value);
      longint sval;
      sval = value;
      case (action)
         ACT_NIL: begin
            push_encoding(1'b1, TAG_NIL, '0, 0);
         end
         ACT_BOOL: begin
            // Only bit 0 decides between true and false.
            push_encoding(1'b1, value[0] ? TAG_TRUE : TAG_FALSE, '0, 0);
         end
         ACT_UNSIGNED: begin
            if (value < POS_FIX_LIMIT)            push_encoding(1'b0, '0, value, 1);
            else if (value <= 64'hFF)             push_encoding(1'b1, TAG_UINT8, value, 1);
            else if (value <= 64'hFFFF)           push_encoding(1'b1, TAG_UINT16, value, 2);
            else if (value <= 64'hFFFF_FFFF)      push_encoding(1'b1, TAG_UINT32, value, 4);
            else                                  push_encoding(1'b1, TAG_UINT64, value, 8);
         end
         ACT_SIGNED: begin
            // Positive values that do not fit a fixint fall through to int16 and up,
            // never to int8.
            if (sval >= NEG_FIX_LOW && sval < POS_FIX_LIMIT) begin
               push_encoding(1'b0, '0, value, 1);
            end else if (sval >= INT8_LOW && sval < NEG_FIX_LOW) begin
               push_encoding(1'b1, TAG_INT8, value, 1);
            end else if (sval >= INT16_LOW && sval <= INT16_HIGH) begin
               push_encoding(1'b1, TAG_INT16, value, 2);
            end else if (sval >= INT32_LOW && sval <= INT32_HIGH) begin
               push_encoding(1'b1, TAG_INT32, value, 4);
            end else begin
               push_encoding(1'b1, TAG_INT64, value, 8);
            end
         end
         ACT_FLOAT32: begin
            // The upper half of the payload plays no part.
            push_encoding(1'b1, TAG_FLOAT32, {32'd0, value[31:0]}, 4);
         end
         ACT_FLOAT64: begin
            push_encoding(1'b1, TAG_FLOAT64, value, 8);
         end
         default: begin
            // Unused codes are swallowed by the encoder.
         end
      endcase
   endfunction

   // Random payloads: fully random, short positive, short negative, or close to a size
   // boundary (optionally negated).
   function automatic logic [63:0] random_payload();
      logic [63:0] v;
      logic [63:0] mask;
      int          width;
      v     = {$urandom, $urandom};
      width = $urandom_range(1, 64);
      mask  = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
      case ($urandom_range(0, 3))
         0: ;
         1: v = v & mask;
         2: v = ~(v & mask);
         default: begin
            v = (64'd1 << SIZE_EDGES[$urandom_range(0, 8)]) - 64'd2
                + 64'($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [2:0] random_action();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)       return ACT_NIL;
      else if (pick < 11) return ACT_BOOL;
      else if (pick < 40) return ACT_UNSIGNED;
      else if (pick < 74) return ACT_SIGNED;
      else if (pick < 84) return ACT_FLOAT32;
      else if (pick < 95) return ACT_FLOAT64;
      else if (pick < 98) return ACT_UNUSED_6;
      else                return ACT_UNUSED_7;
   endfunction

   // Request side. A scalar word is offered from the queue, held until accepted, and
   // followed by an idle gap of random length, possibly none, drawn when it was offered.
   // Every 80 accepted words there is a stretch of 24 sent back to back. The prediction is
   // made where the handshake completes, from the values the encoder samples at that edge.
   always @(posedge clock) begin : req_side
      scalar_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_scalar(req_tuser[2:0], req_tdata);
            action_hits[req_tuser[2:0]]++;
            scalars_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap    <= req_gap - 1;
            end else if (scalars_to_send.size() != 0) begin
               nxt = scalars_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tuser  <= {5'd0, nxt.action};
               req_gap    <= ((scalars_accepted % 80) >= 56) ? 0 : $urandom_range(0, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side. Each accepted byte word is compared with the oldest expected byte,
   // then the receiver may pause at random, except in a stretch of 30 bytes out of every
   // 100. Once, after enough scalars have gone in, it holds tready low for a long stretch
   // so that the encoder's queue fills and it backs up its request side.
   always @(posedge clock) begin : rsp_side
      int           stall;
      enc_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         stall = rsp_stall;
         if (rsp_tvalid && rsp_tready) begin
            if (encoded_bytes_due.size() == 0) begin
               $display("%0t: unexpected byte: expected none, got data %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = encoded_bytes_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: data mismatch: expected %h, got %h",
                           $time, want.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last mismatch: expected %b, got %b",
                           $time, want.last, rsp_tlast);
                  mismatches++;
               end
            end
            bytes_checked++;
            stall = ((bytes_checked % 100) >= 70) ? 0 : $urandom_range(0, 5);
         end
         if (!hold_begun && scalars_accepted >= HOLD_AFTER) begin
            hold_begun <= 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall  <= 0;
         end
      end
   end

   function automatic void queue_scalar(input logic [2:0] action, input logic [63:0] value);
      scalar_type pending;
      pending.action = action;
      pending.value  = value;
      scalars_to_send.insert(scalars_to_send.size(), pending);
      scalars_queued++;
   endfunction

   initial begin : stimulus
      int n;

      // Directed words: every action, the size boundaries of both integer kinds, the
      // bits that booleans and float32 ignore, and the two unused action codes.
      queue_scalar(ACT_NIL,      64'hDEAD_BEEF_0123_4567);
      queue_scalar(ACT_BOOL,     64'h0000_0000_0000_0001);
      queue_scalar(ACT_BOOL,     64'hFFFF_FFFF_FFFF_FFFE);
      queue_scalar(ACT_UNSIGNED, 64'd0);
      queue_scalar(ACT_UNSIGNED, 64'd127);
      queue_scalar(ACT_UNSIGNED, 64'd128);
      queue_scalar(ACT_UNSIGNED, 64'd255);
      queue_scalar(ACT_UNSIGNED, 64'hFFFF);
      queue_scalar(ACT_UNSIGNED, 64'h1_0000);
      queue_scalar(ACT_UNSIGNED, 64'hFFFF_FFFF);
      queue_scalar(ACT_UNSIGNED, 64'h1_0000_0000);
      queue_scalar(ACT_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_scalar(ACT_SIGNED,   -64'sd32);
      queue_scalar(ACT_SIGNED,   -64'sd33);
      queue_scalar(ACT_SIGNED,   64'sd127);
      queue_scalar(ACT_SIGNED,   64'sd128);
      queue_scalar(ACT_SIGNED,   -64'sd128);
      queue_scalar(ACT_SIGNED,   -64'sd129);
      queue_scalar(ACT_SIGNED,   -64'sd32769);
      queue_scalar(ACT_SIGNED,   64'h7FFF_FFFF);
      queue_scalar(ACT_SIGNED,   64'h8000_0000);
      queue_scalar(ACT_SIGNED,   64'h8000_0000_0000_0000);
      queue_scalar(ACT_FLOAT32,  64'hA5A5_5A5A_3F80_0000);
      queue_scalar(ACT_FLOAT64,  64'hC00F_FFFF_FFFF_FFFF);
      queue_scalar(ACT_UNUSED_6, 64'h0123_4567_89AB_CDEF);
      queue_scalar(ACT_UNUSED_7, 64'hFFFF_FFFF_FFFF_FFFF);

      for (n = 0; n < RANDOM_SCALARS; n++) begin
         queue_scalar(random_action(), random_payload());
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every word has been taken, then until every expected byte has come
      // back, then a little longer so that stray bytes would still be caught.
      while (scalars_accepted < scalars_queued) @(posedge clock);
      while (encoded_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d scalars: nil %0d, bool %0d, unsigned %0d, signed %0d,",
               scalars_accepted, action_hits[ACT_NIL], action_hits[ACT_BOOL],
               action_hits[ACT_UNSIGNED], action_hits[ACT_SIGNED]);
      $display("float32 %0d, float64 %0d, dropped codes %0d; %0d bytes checked, %0d errors.",
               action_hits[ACT_FLOAT32], action_hits[ACT_FLOAT64],
               action_hits[ACT_UNUSED_6] + action_hits[ACT_UNUSED_7],
               bytes_checked, mismatches);
      if (mismatches == 0 && encoded_bytes_due.size() == 0) begin
         $display("** msgpack_scalar_encoder: PASSED **");
      end else begin
         $display("** msgpack_scalar_encoder: FAILED **");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout with %0d of %0d scalars accepted, %0d bytes outstanding",
               $time, scalars_accepted, scalars_queued, encoded_bytes_due.size());
      $display("** msgpack_scalar_encoder: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/msc_pkg.sv
rtl/core/msc_classify.sv
rtl/core/msc_queue.sv
rtl/core/msc_serializer.sv
rtl/core/msgpack_scalar_encoder.sv
verif/tb_msgpack_scalar_encoder.sv
